// File: hw/rtl/bpe_pkg.sv
// shared types and constants of the bitmap pixel expander
`timescale 1ns / 1ps

package bpe_pkg;

   localparam int BYTE_W    = 8;
   localparam int DIM_W     = 7;
   localparam int BIR_W     = 6;
   localparam int COL_W     = 9;
   localparam int ROW_W     = 8;
   localparam int COLOR_W   = 16;
   localparam int COORD_W   = 16;
   localparam int PAL_AW    = 4;
   localparam int PAL_DEPTH = 16;
   localparam int STEP_W    = 3;

   localparam logic CMD_PIXEL   = 1'b0;
   localparam logic CMD_PALETTE = 1'b1;

   localparam logic DEPTH_MONO   = 1'b0;
   localparam logic DEPTH_NIBBLE = 1'b1;

   // one byte's worth of drawing work handed from decode to expansion
   typedef struct packed {
      logic                 nibble_mode;
      logic                 dbl;
      logic [BYTE_W-1:0]    mask;
      logic [BIR_W-1:0]     byte_in_row;
      logic [DIM_W-1:0]     row;
      logic [COLOR_W-1:0]   color_hi;
      logic [COLOR_W-1:0]   color_lo;
   } job_type;

endpackage

// File: hw/rtl/bpe_channels.sv
// request and response channel interfaces of the bitmap pixel expander
`timescale 1ns / 1ps

interface bpe_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [7:0]  data_byte;
   logic [3:0]  palette_index;
   logic [15:0] palette_color;

   modport source (output valid, cmd, data_byte, palette_index, palette_color,
                   input ready);
   modport sink (input valid, cmd, data_byte, palette_index, palette_color,
                 output ready);
endinterface

interface bpe_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] pixel_x;
   logic signed [15:0] pixel_y;
   logic [15:0]        pixel_color;
   logic               last_of_run;

   modport source (output valid, pixel_x, pixel_y, pixel_color, last_of_run,
                   input ready);
   modport sink (input valid, pixel_x, pixel_y, pixel_color, last_of_run,
                 output ready);
endinterface

// File: hw/rtl/bpe_ram.sv
// generic ram, one write port and two registered read ports
`timescale 1ns / 1ps

module bpe_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_a,
   output logic [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_a_ff;
   logic [WIDTH-1:0] rdata_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_a_ff <= mem_ff[raddr_a];
      rdata_b_ff <= mem_ff[raddr_b];
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

// File: hw/rtl/bpe_decode.sv
// stream header decode, row tracking, palette store and job stage
`timescale 1ns / 1ps

module bpe_decode #(
   parameter int MAX_DIMENSION = 127
) (
   input  logic             clock,
   input  logic             reset,
   bpe_req_if.sink          req,
   input  logic             depth_mode,
   input  logic             double_scale,
   input  logic             job_ready,
   output logic             job_valid,
   output bpe_pkg::job_type job
);

   localparam logic [1:0] PH_WIDTH  = 2'd0;
   localparam logic [1:0] PH_HEIGHT = 2'd1;
   localparam logic [1:0] PH_PIXELS = 2'd2;

   localparam logic [bpe_pkg::BYTE_W-1:0] DIM_LIMIT = bpe_pkg::BYTE_W'(MAX_DIMENSION);

   logic [1:0]                   phase_ff, phase_in;
   logic [bpe_pkg::DIM_W-1:0]    width_ff, width_in;
   logic [bpe_pkg::DIM_W-1:0]    height_ff, height_in;
   logic [bpe_pkg::DIM_W-1:0]    row_ff, row_in;
   logic [bpe_pkg::BIR_W-1:0]    bir_ff, bir_in;
   logic [bpe_pkg::PAL_DEPTH-1:0] pal_valid_ff, pal_valid_in;
   logic                         job_valid_ff, job_valid_in;
   logic                         fresh_ff, fresh_in;
   logic                         hi_ok_ff, lo_ok_ff;
   bpe_pkg::job_type             job_ff, job_in;

   logic                         accept;
   logic                         pal_write;
   logic                         pixel_byte;
   logic                         load;
   logic [bpe_pkg::DIM_W-1:0]    dim;
   logic [bpe_pkg::BYTE_W-1:0]   row_bytes;
   logic                         row_done;
   logic                         image_done;
   logic [bpe_pkg::BYTE_W-1:0]   mono_mask;
   logic [bpe_pkg::COL_W-1:0]    mono_col;
   logic [bpe_pkg::COLOR_W-1:0]  rdata_hi, rdata_lo;
   logic [bpe_pkg::COLOR_W-1:0]  color_hi_rd, color_lo_rd;

   assign req.ready = !job_valid_ff || job_ready;
   assign accept    = req.valid && req.ready;
   assign pal_write = accept && (req.cmd == bpe_pkg::CMD_PALETTE);
   assign pixel_byte = accept && (req.cmd == bpe_pkg::CMD_PIXEL) && (phase_ff == PH_PIXELS);

   // palette read is issued on every cycle, used only the cycle after a transfer
   bpe_ram #(
      .WIDTH (bpe_pkg::COLOR_W),
      .DEPTH (bpe_pkg::PAL_DEPTH)
   ) u_palette (
      .clock   (clock),
      .we      (pal_write),
      .waddr   (req.palette_index),
      .wdata   (req.palette_color),
      .raddr_a (req.data_byte[7:4]),
      .raddr_b (req.data_byte[3:0]),
      .rdata_a (rdata_hi),
      .rdata_b (rdata_lo)
   );

   // never written entries read as zero
   assign color_hi_rd = hi_ok_ff ? rdata_hi : '0;
   assign color_lo_rd = lo_ok_ff ? rdata_lo : '0;

   always_comb begin
      dim = (req.data_byte > DIM_LIMIT) ? bpe_pkg::DIM_W'(DIM_LIMIT)
                                        : req.data_byte[bpe_pkg::DIM_W-1:0];

      if (depth_mode == bpe_pkg::DEPTH_MONO) begin
         row_bytes = ({1'b0, width_ff} + 8'd7) >> 3;
      end else begin
         row_bytes = ({1'b0, width_ff} + 8'd1) >> 1;
      end
      row_done   = ({2'b00, bir_ff} + 8'd1) >= row_bytes;
      image_done = ({1'b0, row_ff} + 8'd1) >= {1'b0, height_ff};

      // bit k of the mask is column 8*byte_in_row+k, msb of the byte first
      for (int k = 0; k < bpe_pkg::BYTE_W; k++) begin
         mono_col     = {bir_ff, 3'b000} + bpe_pkg::COL_W'(k);
         mono_mask[k] = req.data_byte[bpe_pkg::BYTE_W-1-k] &&
                        (mono_col < {2'b00, width_ff});
      end

      load = pixel_byte && ((depth_mode == bpe_pkg::DEPTH_NIBBLE) || (mono_mask != '0));
   end

   always_comb begin
      phase_in     = phase_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      row_in       = row_ff;
      bir_in       = bir_ff;
      pal_valid_in = pal_valid_ff;

      if (pal_write) begin
         pal_valid_in[req.palette_index] = 1'b1;
      end

      if (accept && (req.cmd == bpe_pkg::CMD_PIXEL)) begin
         case (phase_ff)
            PH_WIDTH: begin
               width_in = dim;
               phase_in = PH_HEIGHT;
            end
            PH_PIXELS: begin
               if (row_done) begin
                  bir_in = '0;
                  if (image_done) begin
                     row_in   = '0;
                     phase_in = PH_WIDTH;
                  end else begin
                     row_in = row_ff + 1'b1;
                  end
               end else begin
                  bir_in = bir_ff + 1'b1;
               end
            end
            default: begin
               height_in = dim;
               row_in    = '0;
               bir_in    = '0;
               phase_in  = ((width_ff == '0) || (dim == '0)) ? PH_WIDTH : PH_PIXELS;
            end
         endcase
      end

      if (load) begin
         job_valid_in = 1'b1;
      end else if (job_ready) begin
         job_valid_in = 1'b0;
      end else begin
         job_valid_in = job_valid_ff;
      end
      fresh_in = load;

      job_in = job_ff;
      if (fresh_ff) begin
         job_in.color_hi = color_hi_rd;
         job_in.color_lo = color_lo_rd;
      end
      if (load) begin
         job_in.nibble_mode = depth_mode;
         job_in.dbl         = double_scale;
         job_in.mask        = mono_mask;
         job_in.byte_in_row = bir_ff;
         job_in.row         = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_WIDTH;
         width_ff     <= '0;
         height_ff    <= '0;
         row_ff       <= '0;
         bir_ff       <= '0;
         pal_valid_ff <= '0;
         job_valid_ff <= 1'b0;
         fresh_ff     <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         row_ff       <= row_in;
         bir_ff       <= bir_in;
         pal_valid_ff <= pal_valid_in;
         job_valid_ff <= job_valid_in;
         fresh_ff     <= fresh_in;
      end
   end

   always_ff @(posedge clock) begin
      hi_ok_ff <= pal_valid_ff[req.data_byte[7:4]];
      lo_ok_ff <= pal_valid_ff[req.data_byte[3:0]];
      job_ff   <= job_in;
   end

   always_comb begin
      job = job_ff;
      if (fresh_ff) begin
         job.color_hi = color_hi_rd;
         job.color_lo = color_lo_rd;
      end
   end

   assign job_valid = job_valid_ff;

endmodule

// File: hw/rtl/bpe_expand.sv
// pixel expansion, one pixel write per cycle into the output register unless the receiver stalls
`timescale 1ns / 1ps

module bpe_expand #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        job_valid,
   input  bpe_pkg::job_type            job,
   output logic                        job_ready,
   input  logic signed [15:0]          origin_x,
   input  logic signed [15:0]          origin_y,
   input  logic [bpe_pkg::COLOR_W-1:0] draw_color,
   bpe_rsp_if.source                   rsp
);

   localparam logic [bpe_pkg::STEP_W-1:0] LAST_SINGLE = 3'd1;
   localparam logic [bpe_pkg::STEP_W-1:0] LAST_DOUBLE = 3'd7;

   logic                          busy_ff, busy_in;
   bpe_pkg::job_type              cur_ff, cur_in;
   logic [bpe_pkg::STEP_W-1:0]    step_ff, step_in;
   logic                          out_valid_ff, out_valid_in;
   logic signed [15:0]            out_x_ff, out_x_in;
   logic signed [15:0]            out_y_ff, out_y_in;
   logic [bpe_pkg::COLOR_W-1:0]   out_color_ff, out_color_in;
   logic                          out_last_ff, out_last_in;

   logic                          emit;
   logic                          load;
   logic                          last;
   logic [2:0]                    first_k;
   logic [bpe_pkg::BYTE_W-1:0]    mask_left;
   logic                          nib;
   logic                          dx;
   logic                          dy;
   logic [bpe_pkg::DIM_W-1:0]     cnib;
   logic [bpe_pkg::COL_W-1:0]     col;
   logic [bpe_pkg::ROW_W-1:0]     row;
   logic [bpe_pkg::COLOR_W-1:0]   color;
   logic [COORD_WIDTH-1:0]        sum_x;
   logic [COORD_WIDTH-1:0]        sum_y;

   assign emit      = busy_ff && (!out_valid_ff || rsp.ready);
   assign job_ready = !busy_ff || (emit && last);
   assign load      = job_valid && job_ready;

   always_comb begin
      // lowest set mask bit is the leftmost remaining pixel
      first_k = '0;
      for (int k = bpe_pkg::BYTE_W - 1; k >= 0; k--) begin
         if (cur_ff.mask[k]) begin
            first_k = 3'(k);
         end
      end
      mask_left = cur_ff.mask & ~(8'd1 << first_k);

      nib  = cur_ff.dbl ? step_ff[2] : step_ff[0];
      dx   = step_ff[0] ^ step_ff[1];
      dy   = step_ff[1];
      cnib = {cur_ff.byte_in_row, 1'b0} + bpe_pkg::DIM_W'(nib);

      if (cur_ff.nibble_mode == bpe_pkg::DEPTH_MONO) begin
         col   = {cur_ff.byte_in_row, 3'b000} + bpe_pkg::COL_W'(first_k);
         row   = {1'b0, cur_ff.row};
         color = draw_color;
         last  = (mask_left == '0);
      end else if (cur_ff.dbl) begin
         // 2x2 block order: top left, top right, bottom right, bottom left
         col   = {1'b0, cnib, dx};
         row   = {cur_ff.row, dy};
         color = nib ? cur_ff.color_lo : cur_ff.color_hi;
         last  = (step_ff == LAST_DOUBLE);
      end else begin
         col   = {2'b00, cnib};
         row   = {1'b0, cur_ff.row};
         color = nib ? cur_ff.color_lo : cur_ff.color_hi;
         last  = (step_ff == LAST_SINGLE);
      end

      sum_x = COORD_WIDTH'(origin_x) + COORD_WIDTH'(col);
      sum_y = COORD_WIDTH'(origin_y) + COORD_WIDTH'(row);
   end

   always_comb begin
      busy_in = busy_ff;
      cur_in  = cur_ff;
      step_in = step_ff;
      if (emit) begin
         step_in     = step_ff + 1'b1;
         cur_in.mask = mask_left;
         if (last) begin
            busy_in = 1'b0;
         end
      end
      if (load) begin
         busy_in = 1'b1;
         cur_in  = job;
         step_in = '0;
      end

      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end

      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_color_in = out_color_ff;
      out_last_in  = out_last_ff;
      if (emit) begin
         out_x_in     = 16'($signed(sum_x));
         out_y_in     = 16'($signed(sum_y));
         out_color_in = color;
         out_last_in  = last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      step_ff      <= step_in;
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
      out_color_ff <= out_color_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.pixel_x     = out_x_ff;
   assign rsp.pixel_y     = out_y_ff;
   assign rsp.pixel_color = out_color_ff;
   assign rsp.last_of_run = out_last_ff;

endmodule

// File: hw/rtl/bitmap_pixel_expander_unit.sv
// top level of the bitmap pixel expander
`timescale 1ns / 1ps

// bitmap pixel expander: turns a stream of image bytes into pixel writes
// - req_chan carries image bytes (cmd 0) and palette entry writes (cmd 1);
//   the first two image bytes are width and height, the rest are pixel data
// - rsp_chan carries one pixel write per transfer, last_of_run marks the
//   final pixel of a byte; headers, palette writes and empty mono bytes
//   give no transfer
// - csr port sets origin, depth mode, double scale and draw colour; write
//   only while the block is idle
// - a byte's pixels pass the job stage with palette read, the expander and
//   the output register in that order
// - the expander gives one pixel per cycle while the receiver takes them; a
//   mono byte gives one pixel per set bit in the image, a four bit byte two
//   pixels, or eight with double scale
// - the next byte is taken while the expander works on the current one, so
//   pixel writes follow without gaps across bytes
// - reset clears the stream state and the palette valid bits, so every
//   palette entry reads as zero until written; no clearing pass
// - when the receiver stalls the output register holds, the expander waits,
//   and req_chan.ready drops once the job stage is full
module bitmap_pixel_expander_unit #(
   parameter int MAX_DIMENSION = 127,
   parameter int COORD_WIDTH   = 16
) (
   input  logic        clock,
   input  logic        reset,
   bpe_req_if.sink     req_chan,
   bpe_rsp_if.source   rsp_chan,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   // register indexes of the csr port
   localparam logic [2:0] CSR_ORIGIN_X     = 3'd0;
   localparam logic [2:0] CSR_ORIGIN_Y     = 3'd1;
   localparam logic [2:0] CSR_DEPTH_MODE   = 3'd2;
   localparam logic [2:0] CSR_DOUBLE_SCALE = 3'd3;
   localparam logic [2:0] CSR_DRAW_COLOR   = 3'd4;

   logic signed [15:0]           origin_x_ff, origin_x_in;
   logic signed [15:0]           origin_y_ff, origin_y_in;
   logic                         depth_mode_ff, depth_mode_in;
   logic                         double_scale_ff, double_scale_in;
   logic [bpe_pkg::COLOR_W-1:0]  draw_color_ff, draw_color_in;

   logic                         job_valid;
   logic                         job_ready;
   bpe_pkg::job_type             job;

   // configuration writes, indexes beyond the list are ignored
   always_comb begin
      origin_x_in     = origin_x_ff;
      origin_y_in     = origin_y_ff;
      depth_mode_in   = depth_mode_ff;
      double_scale_in = double_scale_ff;
      draw_color_in   = draw_color_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ORIGIN_X:     origin_x_in     = csr_wdata;
            CSR_ORIGIN_Y:     origin_y_in     = csr_wdata;
            CSR_DEPTH_MODE:   depth_mode_in   = csr_wdata[0];
            CSR_DOUBLE_SCALE: double_scale_in = csr_wdata[0];
            CSR_DRAW_COLOR:   draw_color_in   = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff     <= '0;
         origin_y_ff     <= '0;
         depth_mode_ff   <= bpe_pkg::DEPTH_MONO;
         double_scale_ff <= 1'b0;
         draw_color_ff   <= 16'hFFFF;
      end else begin
         origin_x_ff     <= origin_x_in;
         origin_y_ff     <= origin_y_in;
         depth_mode_ff   <= depth_mode_in;
         double_scale_ff <= double_scale_in;
         draw_color_ff   <= draw_color_in;
      end
   end

   // header decode, row tracking and palette lookup
   bpe_decode #(
      .MAX_DIMENSION (MAX_DIMENSION)
   ) u_decode (
      .clock        (clock),
      .reset        (reset),
      .req          (req_chan),
      .depth_mode   (depth_mode_ff),
      .double_scale (double_scale_ff),
      .job_ready    (job_ready),
      .job_valid    (job_valid),
      .job          (job)
   );

   // one pixel write per cycle into the output register unless the receiver stalls
   bpe_expand #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_expand (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (job_valid),
      .job        (job),
      .job_ready  (job_ready),
      .origin_x   (origin_x_ff),
      .origin_y   (origin_y_ff),
      .draw_color (draw_color_ff),
      .rsp        (rsp_chan)
   );

endmodule

// File: verif/tb_bitmap_pixel_expander_unit.sv
// self-checking testbench of the bitmap pixel expander with its own pixel predictor
`timescale 1ns / 1ps

module tb_bitmap_pixel_expander_unit;

   localparam int MAX_DIM        = 127;
   localparam int DRAIN_CYCLES   = 12;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_PHASES  = 8;
   localparam int ITEMS_PER_PHASE = 43;

   // register map of the csr port, in the order of the block's register list
   typedef enum logic [2:0] {
      REG_ORIGIN_X     = 3'd0,
      REG_ORIGIN_Y     = 3'd1,
      REG_DEPTH_MODE   = 3'd2,
      REG_DOUBLE_SCALE = 3'd3,
      REG_DRAW_COLOUR  = 3'd4
   } csr_reg_type;

   // where the byte stream stands inside the current image
   typedef enum logic [1:0] {
      ST_WIDTH  = 2'd0,
      ST_HEIGHT = 2'd1,
      ST_PIXELS = 2'd2
   } stream_phase_type;

   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] colour;
      logic        last;
   } pixel_type;

   // predicts the pixel writes of each accepted transfer and checks the block's output
   class pixel_scoreboard_type;
      logic [15:0]      org_x;
      logic [15:0]      org_y;
      logic             depth;
      logic             dbl;
      logic [15:0]      pen_colour;
      stream_phase_type phase;
      logic [6:0]       width;
      logic [6:0]       height;
      logic [6:0]       row;
      logic [5:0]       bir;
      logic [15:0]      palette [16];
      pixel_type        expected_pixels [$];
      int               errors;

      function new();
         org_x      = '0;
         org_y      = '0;
         depth      = bpe_pkg::DEPTH_MONO;
         dbl        = 1'b0;
         pen_colour = 16'hFFFF;
         phase      = ST_WIDTH;
         width      = '0;
         height     = '0;
         row        = '0;
         bir        = '0;
         errors     = 0;
         foreach (palette[i]) palette[i] = '0;
      endfunction

      function void set_reg(csr_reg_type idx, logic [15:0] value);
         case (idx)
            REG_ORIGIN_X:     org_x = value;
            REG_ORIGIN_Y:     org_y = value;
            REG_DEPTH_MODE:   depth = value[0];
            REG_DOUBLE_SCALE: dbl = value[0];
            REG_DRAW_COLOUR:  pen_colour = value;
            default: ;
         endcase
      endfunction

      function void push_pixel(int col, int r, logic [15:0] colour);
         pixel_type p;
         p.x      = org_x + col[15:0];
         p.y      = org_y + r[15:0];
         p.colour = colour;
         p.last   = 1'b0;
         expected_pixels.push_back(p);
      endfunction

      function void push_nibble(int col, int r, logic [15:0] colour);
         if (dbl) begin
            push_pixel(2 * col, 2 * r, colour);
            push_pixel(2 * col + 1, 2 * r, colour);
            push_pixel(2 * col + 1, 2 * r + 1, colour);
            push_pixel(2 * col, 2 * r + 1, colour);
         end else begin
            push_pixel(col, r, colour);
         end
      endfunction

      function void note_request(logic cmd, logic [7:0] b, logic [3:0] pidx, logic [15:0] pcol);
         int dim;
         int row_len;
         int col;
         int n_before;
         dim = (b > MAX_DIM) ? MAX_DIM : int'(b);
         if (cmd == bpe_pkg::CMD_PALETTE) begin
            palette[pidx] = pcol;
         end else if (phase == ST_WIDTH) begin
            width = dim[6:0];
            phase = ST_HEIGHT;
         end else if (phase == ST_HEIGHT) begin
            height = dim[6:0];
            row    = '0;
            bir    = '0;
            phase  = (width == 0 || height == 0) ? ST_WIDTH : ST_PIXELS;
         end else begin
            n_before = expected_pixels.size();
            if (depth == bpe_pkg::DEPTH_MONO) begin
               row_len = (int'(width) + 7) / 8;
               for (int k = 0; k < 8; k++) begin
                  col = int'(bir) * 8 + k;
                  if (b[7-k] && col < int'(width)) push_pixel(col, int'(row), pen_colour);
               end
            end else begin
               row_len = (int'(width) + 1) / 2;
               push_nibble(2 * int'(bir), int'(row), palette[b[7:4]]);
               push_nibble(2 * int'(bir) + 1, int'(row), palette[b[3:0]]);
            end
            if (expected_pixels.size() > n_before)
               expected_pixels[expected_pixels.size()-1].last = 1'b1;
            if (int'(bir) + 1 >= row_len) begin
               bir = '0;
               row = row + 7'd1;
               if (row >= height) begin
                  row   = '0;
                  phase = ST_WIDTH;
               end
            end else begin
               bir = bir + 6'd1;
            end
         end
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (want !== got) begin
            $display("%0t ns: %s expected %h actual %h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_pixel(logic [15:0] x, logic [15:0] y, logic [15:0] colour,
                                logic last);
         pixel_type want;
         if (expected_pixels.size() == 0) begin
            $display("%0t ns: unexpected pixel expected none actual x %0d y %0d colour %h",
                     $time, $signed(x), $signed(y), colour);
            errors++;
         end else begin
            want = expected_pixels.pop_front();
            compare_field("pixel_x", want.x, x);
            compare_field("pixel_y", want.y, y);
            compare_field("pixel_color", want.colour, colour);
            compare_field("last_of_run", {15'd0, want.last}, {15'd0, last});
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   bpe_req_if req_chan ();
   bpe_rsp_if rsp_chan ();

   pixel_scoreboard_type sb;
   int                   send_run;
   int                   take_run;
   int                   quiet_cycles;
   bit                   tall_done;

   bitmap_pixel_expander_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 2 ns clock
   always #1 clock = ~clock;

   // number of idle cycles before the next transfer; now and then a run of back-to-back transfers
   function automatic int draw_wait(inout int run_left);
      if (run_left > 0) begin
         run_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         run_left = $urandom_range(10, 30);
         return 0;
      end
      return $urandom_range(0, 3);
   endfunction

   // one request transfer; called and returning at a rising edge
   // valid stays high across back-to-back transfers so it is never lowered and raised in one step
   task automatic send_item(logic cmd, logic [7:0] b, logic [3:0] pidx, logic [15:0] pcol);
      int gap;
      gap = draw_wait(send_run);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.cmd           <= cmd;
      req_chan.data_byte     <= b;
      req_chan.palette_index <= pidx;
      req_chan.palette_color <= pcol;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_request(cmd, b, pidx, pcol);
   endtask

   // image byte with random don't-care palette fields
   task automatic send_byte(logic [7:0] b);
      send_item(bpe_pkg::CMD_PIXEL, b, 4'($urandom), 16'($urandom));
   endtask

   // palette entry write with a random don't-care data byte
   task automatic send_palette(logic [3:0] pidx, logic [15:0] pcol);
      send_item(bpe_pkg::CMD_PALETTE, 8'($urandom), pidx, pcol);
   endtask

   // one register write; csr_we is left high for the caller to lower after the last one
   task automatic csr_put(csr_reg_type idx, logic [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.set_reg(idx, value);
   endtask

   task automatic apply_config(logic [15:0] ox, logic [15:0] oy, logic depth, logic dbl,
                               logic [15:0] colour);
      csr_put(REG_ORIGIN_X, ox);
      csr_put(REG_ORIGIN_Y, oy);
      csr_put(REG_DEPTH_MODE, {15'd0, depth});
      csr_put(REG_DOUBLE_SCALE, {15'd0, dbl});
      csr_put(REG_DRAW_COLOUR, colour);
      csr_we <= 1'b0;
   endtask

   // stop offering, let every expected pixel arrive, then allow for bytes still in flight
   // that draw nothing
   task automatic end_phase();
      req_chan.valid <= 1'b0;
      while (sb.expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // random item that follows the stream: headers while a header is due, pixel bytes otherwise,
   // with palette writes thrown in as noise
   task automatic random_item();
      logic [7:0] b;
      int         roll;
      roll = $urandom_range(0, 11);
      if (roll == 0) begin
         send_palette(4'($urandom), 16'($urandom));
      end else begin
         case (sb.phase)
            ST_WIDTH: begin
               if (roll == 1)      b = 8'd0;
               else if (roll == 2) b = 8'($urandom_range(128, 255));
               else                b = 8'($urandom_range(1, 24));
            end
            ST_HEIGHT: begin
               // keep oversized images short: saturated width gets at most one row,
               // saturated height only once and on a one-byte row
               if (sb.width == 0)
                  b = 8'($urandom);
               else if (sb.width == MAX_DIM)
                  b = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'd1;
               else if (sb.width <= 2 && !tall_done && $urandom_range(0, 3) == 0) begin
                  b = 8'($urandom_range(128, 255));
                  tall_done = 1'b1;
               end else if (roll == 1)
                  b = 8'd0;
               else
                  b = 8'($urandom_range(1, 5));
            end
            default: begin
               if (roll <= 3)      b = 8'h00;
               else if (roll <= 6) b = 8'hFF;
               else                b = 8'($urandom);
            end
         endcase
         send_byte(b);
      end
   endtask

   // every rsp transfer is checked against the oldest predicted pixel
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         sb.check_pixel(rsp_chan.pixel_x, rsp_chan.pixel_y, rsp_chan.pixel_color,
                        rsp_chan.last_of_run);
   end

   // watchdog: too long without any transfer on either channel ends the run
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // receiver: random stalls per pixel, plus long hold-offs so the block backs up into req_chan
   initial begin : rsp_side
      int stall;
      int taken;
      taken = 0;
      @(negedge reset);
      @(posedge clock);
      forever begin
         if (taken == 150 || taken == 900)
            stall = HOLD_CYCLES;
         else
            stall = draw_wait(take_run);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         taken++;
      end
   end

   initial begin : stimulus
      logic [15:0] corner [4];
      logic [15:0] ox;
      logic [15:0] oy;
      logic [15:0] colour;
      logic        depth;
      logic        dbl;
      sb           = new();
      send_run     = 0;
      take_run     = 0;
      quiet_cycles = 0;
      tall_done    = 1'b0;
      corner       = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};

      // every input known from time zero
      reset                  <= 1'b1;
      csr_we                 <= 1'b0;
      csr_index              <= REG_ORIGIN_X;
      csr_wdata              <= '0;
      req_chan.valid         <= 1'b0;
      req_chan.cmd           <= bpe_pkg::CMD_PIXEL;
      req_chan.data_byte     <= '0;
      req_chan.palette_index <= '0;
      req_chan.palette_color <= '0;
      rsp_chan.ready         <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: mono, origin at zero, white pen
      send_palette(4'h0, 16'hFFFF);
      send_palette(4'hF, 16'h0000);
      send_byte(8'd0);               // zero width: empty image, height byte ends it
      send_byte(8'd9);
      send_byte(8'd5);               // zero height: empty image
      send_byte(8'd0);
      send_byte(8'd10);              // ten wide, one row of two bytes
      send_byte(8'd1);
      send_byte(8'hFF);              // full byte, eight pixels
      send_byte(8'hFF);              // only two columns left, padding bits draw nothing
      end_phase();

      // four bit with double scale, origin right at the wrap point
      apply_config(16'h7FFF, 16'hFFFF, bpe_pkg::DEPTH_NIBBLE, 1'b1, 16'h0000);
      send_palette(4'h5, 16'hA5C3);
      send_byte(8'd3);               // odd width: low nibble of the last byte still draws
      send_byte(8'd1);
      send_byte(8'h5F);
      send_byte(8'hF5);
      end_phase();

      // four bit, start a sixteen wide image and leave it part way through a row
      apply_config(16'h8000, 16'h7FF0, bpe_pkg::DEPTH_NIBBLE, 1'b0, 16'h8001);
      send_byte(8'd16);
      send_byte(8'd2);
      send_byte(8'h12);
      send_byte(8'h34);
      send_byte(8'h56);
      end_phase();

      // mono mid-image: byte position is already past the shorter mono row, so the row ends
      apply_config(16'hFFFF, 16'h0000, bpe_pkg::DEPTH_MONO, 1'b0, 16'h1234);
      send_byte(8'hC3);              // columns beyond the width, nothing drawn
      send_byte(8'hFF);
      send_byte(8'h81);
      end_phase();

      // random phases, corner settings first; a phase may end mid-image
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         ox     = (p < 4) ? corner[p] : 16'($urandom);
         oy     = (p < 4) ? corner[3-p] : 16'($urandom);
         depth  = (p < 4) ? p[0] : 1'($urandom);
         dbl    = (p < 4) ? p[1] : 1'($urandom);
         colour = (p == 0) ? 16'h0000 : (p == 1) ? 16'hFFFF : 16'($urandom);
         apply_config(ox, oy, depth, dbl, colour);
         repeat (ITEMS_PER_PHASE) random_item();
         end_phase();
      end

      if (sb.errors == 0 && sb.expected_pixels.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/bpe_pkg.sv
hw/rtl/bpe_channels.sv
hw/rtl/bpe_ram.sv
hw/rtl/bpe_decode.sv
hw/rtl/bpe_expand.sv
hw/rtl/bitmap_pixel_expander_unit.sv
verif/tb_bitmap_pixel_expander_unit.sv
